[src/asc2u_pkg.sv]
// Shared types, character codes and the digit map of the ASCII to unsigned parser.
package asc2u_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] BASE_AUTO   = 6'd0;
  localparam logic [5:0] BASE_OCT    = 6'd8;
  localparam logic [5:0] BASE_DEC    = 6'd10;
  localparam logic [5:0] BASE_HEX    = 6'd16;
  localparam logic [5:0] BASE_MIN    = 6'd2;
  localparam logic [5:0] MAX_BASE    = 6'd36;

  localparam logic [6:0] NOT_DIGIT = 7'd100;

  // Map 0-9, A-Z, a-z to 0..35; anything else is not a digit.
  function automatic logic [6:0] digit_of(logic [7:0] c);
    logic [6:0] d;
    d = NOT_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 7'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = 7'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = 7'(c - 8'h57);
    end
    return d;
  endfunction

endpackage

[src/ascii_to_unsigned_parser_core.sv]
// Top level of the streaming ASCII to unsigned integer parser.
//
//  port group   dir  payload (low bit first)              meaning
//  s_axis       in   tdata: ch[7:0]; tuser: first         one character per word
//  m_axis       out  tdata: value, end_offset, zero fill; one result per number
//                    tuser: overflowed, no_digits
//  radix_*      in   radix_wdata_i[5:0]                   base 2..36, 0 = auto
//
// Flow: one character word per clock while the result side takes words; a word
// waits in the input register, and the parse step loads its result into the result register.
// The 32-by-6 multiply-add in the parse step sets the clock path.
// Reset: asynchronous, clears the parse to idle and radix to ten.
// Stalls: a held result word stops the parse step, which backs up the input
// register and then s_axis_tready_o; words without a result also wait then.
module ascii_to_unsigned_parser_core #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned TDATA_W   = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] ch
  input  logic               s_axis_tuser_i,   // [0] first
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // value, end_offset, zero fill
  output logic [1:0]         m_axis_tuser_o,   // [0] overflowed, [1] no_digits
  input  logic               radix_we_i,
  input  logic [5:0]         radix_wdata_i
);
  import asc2u_pkg::*;

  logic [5:0]            radix_q;
  logic                  in_valid, in_first, take, out_free;
  logic [7:0]            in_ch;
  logic                  res_valid, res_ovf, res_nodig;
  logic [VALUE_BITS-1:0] res_value;
  logic [COUNT_BITS-1:0] res_offset;

  // Radix register; sampled by the parse on a first-flagged character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_wdata_i;
    end
  end

  // Advance the held character whenever the result register can take a word.
  assign take = in_valid && out_free;

  asc2u_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .take_i          (take),
    .valid_o         (in_valid),
    .ch_o            (in_ch),
    .first_o         (in_first)
  );

  asc2u_parse #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .ch_i         (in_ch),
    .first_i      (in_first),
    .radix_i      (radix_q),
    .res_valid_o  (res_valid),
    .res_value_o  (res_value),
    .res_offset_o (res_offset),
    .res_ovf_o    (res_ovf),
    .res_nodig_o  (res_nodig)
  );

  asc2u_out_stage #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .TDATA_W    (TDATA_W)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (res_valid),
    .value_i         (res_value),
    .offset_i        (res_offset),
    .ovf_i           (res_ovf),
    .nodig_i         (res_nodig),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // A number without digits reports zero value, zero length and no overflow.
  a_nodig_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == '0 && !m_axis_tuser_o[0]))
    else $error("no-digit result carries nonzero fields");

  // Overflow saturates the value to all ones.
  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (&m_axis_tdata_o[VALUE_BITS-1:0]))
    else $error("overflowed result not saturated");

  // A result is only produced from a held character while the output has room.
  a_res_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_valid && out_free))
    else $error("result produced without a character to process");

  // A loaded result is visible on the next cycle.
  a_res_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid_o)
    else $error("result word lost");

endmodule

[src/asc2u_in_stage.sv]
// Input register of the parser: holds one accepted character word.
module asc2u_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] ch
  input  logic       s_axis_tuser_i,   // [0] first
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] ch_o,
  output logic       first_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       first_q;
  logic       load;

  assign s_axis_tready_o = !valid_q || take_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q    <= s_axis_tdata_i;
      first_q <= s_axis_tuser_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign first_o = first_q;

endmodule

[src/asc2u_parse.sv]
// Parse state and per-character step: prefix handling, multiply-add and result.
module asc2u_parse #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            ch_i,
  input  logic                  first_i,
  input  logic [5:0]            radix_i,
  output logic                  res_valid_o,
  output logic [VALUE_BITS-1:0] res_value_o,
  output logic [COUNT_BITS-1:0] res_offset_o,
  output logic                  res_ovf_o,
  output logic                  res_nodig_o
);
  import asc2u_pkg::*;

  localparam int unsigned PROD_W = VALUE_BITS + 6;
  localparam int unsigned SUM_W  = VALUE_BITS + 1;

  phase_e                phase_q, phase_d, ph_e;
  logic [VALUE_BITS-1:0] accum_q, accum_d, acc_e;
  logic                  ovf_q, ovf_d, ovf_e;
  logic                  saw_q, saw_d, saw_e;
  logic [5:0]            base_q, base_d, base_e;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_e, cnt_inc;

  logic                  lead_skip, at_start, zero_pfx, x_pfx;
  logic                  try_digit, digit_ok, emit, bump, dig_saw;
  logic [5:0]            dig_base;
  logic [6:0]            digit;
  logic [PROD_W-1:0]     mul;
  logic [SUM_W-1:0]      sum;
  logic                  mul_ovf, add_ovf;

  // A first flag restarts the parse on this very character.
  always_comb begin
    if (first_i) begin
      ph_e   = PH_LEAD;
      acc_e  = '0;
      ovf_e  = 1'b0;
      saw_e  = 1'b0;
      base_e = radix_i;
      cnt_e  = '0;
    end else begin
      ph_e   = phase_q;
      acc_e  = accum_q;
      ovf_e  = ovf_q;
      saw_e  = saw_q;
      base_e = base_q;
      cnt_e  = cnt_q;
    end
  end

  // Classify the character against the current phase.
  always_comb begin
    digit     = digit_of(ch_i);
    lead_skip = (ph_e == PH_LEAD) && (ch_i == CH_SPACE || ch_i == CH_PLUS);
    at_start  = ((ph_e == PH_LEAD) && !lead_skip) || (ph_e == PH_SIGNED);
    zero_pfx  = at_start && (base_e == BASE_AUTO || base_e == BASE_HEX) && (ch_i == CH_ZERO);
    x_pfx     = (ph_e == PH_ZERO) && (ch_i == CH_X_LO || ch_i == CH_X_UP);
    try_digit = (at_start && !zero_pfx) || ((ph_e == PH_ZERO) && !x_pfx) ||
                (ph_e == PH_DIGITS);
    dig_base  = base_e;
    if (at_start && base_e == BASE_AUTO) begin
      dig_base = BASE_DEC;
    end else if (ph_e == PH_ZERO && base_e == BASE_AUTO) begin
      dig_base = BASE_OCT;
    end
    // A lone leading zero already counts as a digit.
    dig_saw  = saw_e || (ph_e == PH_ZERO);
    digit_ok = try_digit && (dig_base inside {[BASE_MIN:MAX_BASE]}) &&
               (digit < 7'(dig_base));
    emit     = try_digit && !digit_ok;
    bump     = lead_skip || zero_pfx || x_pfx || digit_ok;
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      if (zero_pfx) begin
        phase_d = PH_ZERO;
      end else if (ph_e == PH_LEAD && ch_i == CH_SPACE) begin
        phase_d = PH_LEAD;
      end else if (ph_e == PH_LEAD && ch_i == CH_PLUS) begin
        phase_d = PH_SIGNED;
      end else if (x_pfx || digit_ok) begin
        phase_d = PH_DIGITS;
      end else if (emit) begin
        phase_d = PH_IDLE;
      end else begin
        phase_d = ph_e;
      end
    end
  end

  // Multiply-add with overflow detection on the full-width product and on the sum.
  always_comb begin
    mul     = PROD_W'(acc_e) * PROD_W'(dig_base);
    mul_ovf = |mul[PROD_W-1:VALUE_BITS];
    sum     = SUM_W'(mul[VALUE_BITS-1:0]) + SUM_W'(digit);
    add_ovf = sum[VALUE_BITS];
    cnt_inc = (&cnt_e) ? cnt_e : cnt_e + 1'b1;
  end

  always_comb begin
    accum_d = accum_q;
    ovf_d   = ovf_q;
    saw_d   = saw_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    if (take_i) begin
      accum_d = digit_ok ? sum[VALUE_BITS-1:0] : acc_e;
      ovf_d   = ovf_e || (digit_ok && (mul_ovf || add_ovf));
      saw_d   = digit_ok || (try_digit ? dig_saw : saw_e);
      base_d  = x_pfx ? BASE_HEX : (try_digit ? dig_base : base_e);
      cnt_d   = bump ? cnt_inc : cnt_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      accum_q <= '0;
      ovf_q   <= 1'b0;
      saw_q   <= 1'b0;
      base_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      saw_q   <= saw_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_valid_o  = take_i && emit;
  assign res_value_o  = ovf_e ? '1 : acc_e;
  assign res_offset_o = dig_saw ? cnt_e : '0;
  assign res_ovf_o    = ovf_e;
  assign res_nodig_o  = !dig_saw;

endmodule

[src/asc2u_out_stage.sv]
// Result register of the parser: packs and holds one result word for the sink.
module asc2u_out_stage #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned TDATA_W    = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [COUNT_BITS-1:0] offset_i,
  input  logic                  ovf_i,
  input  logic                  nodig_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [TDATA_W-1:0]    m_axis_tdata_o,  // value, end_offset, zero fill
  output logic [1:0]            m_axis_tuser_o   // [0] overflowed, [1] no_digits
);

  logic               valid_q, valid_d;
  logic [TDATA_W-1:0] tdata_q;
  logic [1:0]         tuser_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tdata_q <= TDATA_W'({offset_i, value_i});
      tuser_q <= {nodig_i, ovf_i};
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule

[tb/ascii_to_unsigned_parser_core_tb.sv]
// Self-checking testbench for the streaming ASCII to unsigned integer parser.
`timescale 1ns / 100ps

module ascii_to_unsigned_parser_core_tb;
  import asc2u_pkg::*;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  localparam logic [5:0] RADIX_TOP      = 6'd63;
  localparam logic [5:0] RADIX_UNIT     = 6'd1;
  localparam logic [5:0] RADIX_PAST_MAX = 6'd37;
  localparam logic [7:0] CH_NUL         = 8'h00;
  localparam logic [7:0] CH_COMMA       = 8'h2C;

  localparam int unsigned CHARS_PER_RADIX = 80;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] end_offset;
    logic               overflowed;
    logic               no_digits;
  } number_t;

  // DUT ports
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i  = '0;   // [7:0] ch
  logic               s_axis_tuser_i  = 1'b0; // [0] first
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;         // value, end_offset
  logic [1:0]         m_axis_tuser_o;         // [0] overflowed, [1] no_digits
  logic               radix_we_i      = 1'b0;
  logic [5:0]         radix_wdata_i   = '0;

  // Stimulus and expectation stores
  char_word_t  char_q[$];
  number_t     number_q[$];
  int unsigned queued_chars;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Shadow parse state
  logic [5:0]         cfg_radix  = RADIX_RESET;
  phase_e             prs_phase  = PH_IDLE;
  logic [VALUE_W-1:0] prs_accum  = '0;
  logic               prs_ovf    = 1'b0;
  logic               prs_saw    = 1'b0;
  logic [5:0]         prs_base   = '0;
  logic [COUNT_W-1:0] prs_count  = '0;

  // Sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_epoch = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned win_left   = 0;
  int unsigned rx_mode    = 0;

  ascii_to_unsigned_parser_core #(
    .VALUE_BITS(VALUE_W),
    .COUNT_BITS(COUNT_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .radix_we_i     (radix_we_i),
    .radix_wdata_i  (radix_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parse predictor
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 7'(c - "0");
    if (c >= "A" && c <= "Z") return 7'(c - "A" + 8'd10);
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd10);
    return NOT_DIGIT;
  endfunction

  task automatic count_char();
    if (prs_count != '1) prs_count++;
  endtask

  // Fold a digit into the running value, or close the number on a non-digit.
  task automatic step_digit(input logic [7:0] c);
    logic [6:0]  d;
    logic [63:0] wide;
    number_t     r;
    d = char_value(c);
    if (prs_base >= BASE_MIN && prs_base <= MAX_BASE && d < {1'b0, prs_base}) begin
      wide = 64'(prs_accum) * 64'(prs_base) + 64'(d);
      if (wide[63:VALUE_W] != '0) prs_ovf = 1'b1;
      prs_accum = wide[VALUE_W-1:0];
      prs_saw   = 1'b1;
      count_char();
    end else begin
      r.value      = prs_ovf ? '1 : prs_accum;
      r.end_offset = prs_saw ? prs_count : '0;
      r.overflowed = prs_ovf;
      r.no_digits  = !prs_saw;
      number_q.push_back(r);
      prs_phase = PH_IDLE;
    end
  endtask

  // First character after blanks and sign: a zero may open a base prefix.
  task automatic step_start(input logic [7:0] c);
    if ((prs_base == BASE_AUTO || prs_base == BASE_HEX) && c == CH_ZERO) begin
      count_char();
      prs_phase = PH_ZERO;
    end else begin
      if (prs_base == BASE_AUTO) prs_base = BASE_DEC;
      prs_phase = PH_DIGITS;
      step_digit(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic first);
    if (first) begin
      prs_accum = '0;
      prs_ovf   = 1'b0;
      prs_saw   = 1'b0;
      prs_count = '0;
      prs_base  = cfg_radix;
      prs_phase = PH_LEAD;
    end
    case (prs_phase)
      PH_LEAD: begin
        if (c == CH_SPACE) begin
          count_char();
        end else if (c == CH_PLUS) begin
          count_char();
          prs_phase = PH_SIGNED;
        end else begin
          step_start(c);
        end
      end
      PH_SIGNED: begin
        step_start(c);
      end
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          count_char();
          prs_base  = BASE_HEX;
          prs_phase = PH_DIGITS;
        end else begin
          // the lone zero is a digit of its own
          prs_saw = 1'b1;
          if (prs_base == BASE_AUTO) prs_base = BASE_OCT;
          prs_phase = PH_DIGITS;
          step_digit(c);
        end
      end
      PH_DIGITS: begin
        step_digit(c);
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] c, input logic first);
    char_word_t w;
    w.ch    = c;
    w.first = first;
    char_q.push_back(w);
    queued_chars++;
  endtask

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) push_char(txt[i], i == 0);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned base);
    int unsigned d;
    if (base >= BASE_MIN && base <= MAX_BASE) d = $urandom_range(0, base - 1);
    else d = $urandom_range(0, 35);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  // One string: mostly well formed (blanks, sign, prefix, digits, end),
  // with some raw noise and some strings cut short by the next restart.
  task automatic queue_string(input logic [5:0] rdx);
    int unsigned kind;
    int unsigned eff;
    int unsigned ndig;
    logic [7:0]  s[$];
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) push_char(8'($urandom), $urandom_range(0, 3) == 0);
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s.push_back(CH_SPACE);
      if ($urandom_range(0, 2) == 0) s.push_back(CH_PLUS);
      eff = rdx;
      if (rdx == BASE_AUTO || rdx == BASE_HEX) begin
        case ($urandom_range(0, 3))
          0: begin
            s.push_back(CH_ZERO);
            s.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            eff = BASE_HEX;
          end
          1: begin
            s.push_back(CH_ZERO);
            if (rdx == BASE_AUTO) eff = BASE_OCT;
          end
          default: begin
            if (rdx == BASE_AUTO) eff = BASE_DEC;
          end
        endcase
      end
      if (kind < 22) ndig = $urandom_range(25, 40);
      else if (kind < 32) ndig = 0;
      else ndig = $urandom_range(1, 10);
      repeat (ndig) s.push_back(digit_char(eff));
      case ($urandom_range(0, 9))
        0:       s.push_back(CH_NUL);
        1, 2:    s.push_back(CH_SPACE);
        3:       s.push_back(CH_COMMA);
        4:       begin end  // leave it open for the next restart
        default: s.push_back(8'($urandom));
      endcase
      foreach (s[i]) push_char(s[i], i == 0);
      // stray characters between strings
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) push_char(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic write_radix(input logic [5:0] v);
    @(posedge clk_i);
    radix_we_i    <= 1'b1;
    radix_wdata_i <= v;
    cfg_radix = v;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
  endtask

  // Wait for the input side to empty, all numbers back, and the pipe settled.
  task automatic drain();
    while (char_q.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (number_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; hold the word until taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (char_q.size() != 0) begin
        w = char_q.pop_front();
        s_axis_tdata_i  <= w.ch;
        s_axis_tuser_i  <= w.first;
        s_axis_tvalid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: windows of differing stall density, plus a long hold on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (hold_seen != hold_epoch) begin
        hold_seen = hold_epoch;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(8, 64);
          rx_mode  = $urandom_range(0, 3);
        end else begin
          win_left--;
        end
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= $urandom_range(0, 3) != 0;
          2:       m_axis_tready_i <= $urandom_range(0, 1);
          default: m_axis_tready_i <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted character, check each accepted number.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    number_t got;
    number_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) parse_char(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.value      = m_axis_tdata_o[VALUE_W-1:0];
        got.end_offset = m_axis_tdata_o[VALUE_W+COUNT_W-1:VALUE_W];
        got.overflowed = m_axis_tuser_o[0];
        got.no_digits  = m_axis_tuser_o[1];
        if (number_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected number: value %h offset %0d ovf %b nodig %b",
                     $realtime, got.value, got.end_offset, got.overflowed, got.no_digits);
          end
        end else begin
          want = number_q.pop_front();
          if (got.value !== want.value || got.end_offset !== want.end_offset ||
              got.overflowed !== want.overflowed || got.no_digits !== want.no_digits) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: value %h/%h offset %0d/%0d ovf %b/%b nodig %b/%b",
                       $realtime, want.value, got.value, want.end_offset, got.end_offset,
                       want.overflowed, got.overflowed, want.no_digits, got.no_digits);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not complete in time", $realtime);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed strings at the reset base, then random strings under a
  // range of bases.
  // ---------------------------------------------------------------------------
  initial begin
    logic [5:0] radix_plan[$];
    radix_plan = '{BASE_AUTO, BASE_HEX, BASE_MIN, MAX_BASE, BASE_OCT,
                   RADIX_TOP, RADIX_UNIT, RADIX_PAST_MAX, BASE_DEC};
    radix_plan.insert(8, 6'($urandom));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_char("q", 1'b0);       // idle, dropped
    queue_text(" +7");
    push_char(CH_NUL, 1'b0);
    queue_text("9");            // abandoned by the restart below
    queue_text("3Z");
    queue_text("+x");           // sign but no digits
    queue_text("0x");           // decimal: zero, then x ends it
    queue_text("42");
    push_char(8'hFF, 1'b0);
    queue_text("99999999999");  // past 32 bits
    push_char(8'h80, 1'b0);
    drain();

    foreach (radix_plan[i]) begin
      write_radix(radix_plan[i]);
      @(negedge clk_i);
      queued_chars = 0;
      if (radix_plan[i] == BASE_HEX) begin
        queue_text("ffffffff ");   // largest value that fits
        queue_text("100000000 ");  // one past it
      end
      while (queued_chars < CHARS_PER_RADIX) queue_string(radix_plan[i]);
      // in auto base, block the result side while words keep coming
      if (radix_plan[i] == BASE_AUTO) hold_epoch++;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && number_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/asc2u_pkg.sv
src/asc2u_in_stage.sv
src/asc2u_parse.sv
src/asc2u_out_stage.sv
src/ascii_to_unsigned_parser_core.sv
tb/ascii_to_unsigned_parser_core_tb.sv
